FILE: rtl/nmme_pkg.sv
// ----------------------------------------------------------------------------
// nmme_pkg
// Shared types, constants and codes for the membership table and election.
// ----------------------------------------------------------------------------
package nmme_pkg;

   localparam int TableDepth = 16;
   localparam int SlotW      = $clog2(TableDepth);
   localparam int CountW     = $clog2(TableDepth + 1);

   localparam logic [2:0] CmdHello   = 3'd0;
   localparam logic [2:0] CmdTick    = 3'd1;
   localparam logic [2:0] CmdCheck   = 3'd2;
   localparam logic [2:0] CmdPromote = 3'd3;
   localparam logic [2:0] CmdDemote  = 3'd4;

   localparam logic [2:0] EvAdded    = 3'd0;
   localparam logic [2:0] EvMaster   = 3'd1;
   localparam logic [2:0] EvHello    = 3'd2;
   localparam logic [2:0] EvRemoved  = 3'd3;
   localparam logic [2:0] EvDemoted  = 3'd4;
   localparam logic [2:0] EvPromoted = 3'd5;
   localparam logic [2:0] EvChecked  = 3'd6;
   localparam logic [2:0] EvFull     = 3'd7;

   localparam logic [2:0] RegNodeTo   = 3'd0;
   localparam logic [2:0] RegMasterTo = 3'd1;
   localparam logic [2:0] RegWeight   = 3'd2;
   localparam logic [2:0] RegMastReq  = 3'd3;
   localparam logic [2:0] RegOwnProc  = 3'd4;
   localparam logic [2:0] RegOwnInst  = 3'd5;
   localparam logic [2:0] RegIgnProc  = 3'd6;
   localparam logic [2:0] RegIgnInst  = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HSCAN, ST_HEMIT, ST_CSCAN, ST_CEMIT
   } state_type;

   // word travelling along the chain of cells
   typedef struct packed {
      logic        valid;
      logic [63:0] process;
      logic [63:0] instance_tag;
      logic [31:0] address;
      logic [15:0] port;
      logic [31:0] seen;
      logic        master;
      logic        eligible;
      logic [31:0] weight;
   } entry_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic shift;     // rotate one place
      logic clear;     // clear valid of the head word during this shift
      logic load;      // overwrite head word with new_entry during this shift
   } ctl_type;

endpackage

FILE: rtl/nmme_cell.sv
// ----------------------------------------------------------------------------
// nmme_cell
// One table slot: holds an entry and passes it on when the ring rotates.
// ----------------------------------------------------------------------------
module nmme_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  nmme_pkg::ctl_type    ctl,
   input  nmme_pkg::entry_type  prev_entry,
   output nmme_pkg::entry_type  entry
);
   nmme_pkg::entry_type entry_ff;
   logic                valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         entry_ff <= prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= prev_entry.valid;
      end
   end

   always_comb begin
      entry       = entry_ff;
      entry.valid = valid_ff;
   end
endmodule

FILE: rtl/nmme_ring.sv
// ----------------------------------------------------------------------------
// nmme_ring
// Ring of table cells; head word can be cleared or replaced as it wraps.
// ----------------------------------------------------------------------------
module nmme_ring (
   input  logic                 clock,
   input  logic                 reset,
   input  nmme_pkg::ctl_type    ctl,
   input  nmme_pkg::entry_type  new_entry,
   output nmme_pkg::entry_type  head
);
   nmme_pkg::entry_type chain [nmme_pkg::TableDepth];
   nmme_pkg::entry_type wrap;

   always_comb begin
      wrap = chain[0];
      if (ctl.load) begin
         wrap = new_entry;
      end else if (ctl.clear) begin
         wrap.valid = 1'b0;
      end
   end

   for (genvar i = 0; i < nmme_pkg::TableDepth; i++) begin : g_cell
      nmme_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry ((i == nmme_pkg::TableDepth - 1) ? wrap : chain[i + 1]),
         .entry      (chain[i])
      );
   end

   assign head = chain[0];
endmodule

FILE: rtl/node_membership_master_election.sv
// Hello makes a lookup pass over the ring, then a write pass into the chosen
// slot (none when the table is full), then one result per cycle, up to 3.
// Check sweeps the ring with removals streamed out, then 1 or 2 more results.
// Results are registered and show in the cycle after they are formed.
// Tick, promote and demote emit nothing; busy falls as the last result shows.
// Sync reset clears valid bits, clock and state; flags, config take defaults.
module node_membership_master_election (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_command,
   input  logic [63:0]  req_process_tag,
   input  logic [63:0]  req_instance_tag,
   input  logic [31:0]  req_sender_address,
   input  logic [15:0]  req_sender_port,
   input  logic         req_claims_master,
   input  logic         req_claims_eligible,
   input  logic signed [31:0] req_sender_weight,
   input  logic         req_permanent,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data,
   output logic         rsp_strobe,
   output logic [2:0]   rsp_event_res,
   output logic [3:0]   rsp_slot,
   output logic [63:0]  rsp_node_process,
   output logic [63:0]  rsp_node_instance,
   output logic         rsp_node_master,
   output logic         rsp_self_master,
   output logic         rsp_last
);
   localparam int SW = nmme_pkg::SlotW;
   localparam int CW = nmme_pkg::CountW;

   // configuration
   logic [15:0] node_to_ff, master_to_ff;
   logic [31:0] weight_ff;
   logic [7:0]  mreq_ff;
   logic [63:0] own_proc_ff, own_inst_ff;
   logic        ign_proc_ff, ign_inst_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_to_ff <= 16'd2; master_to_ff <= 16'd2; weight_ff <= '0;
         mreq_ff <= 8'd1; own_proc_ff <= '0; own_inst_ff <= '0;
         ign_proc_ff <= 1'b1; ign_inst_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            nmme_pkg::RegNodeTo:   node_to_ff   <= csr_data[15:0];
            nmme_pkg::RegMasterTo: master_to_ff <= csr_data[15:0];
            nmme_pkg::RegWeight:   weight_ff    <= csr_data[31:0];
            nmme_pkg::RegMastReq:  mreq_ff      <= csr_data[7:0];
            nmme_pkg::RegOwnProc:  own_proc_ff  <= csr_data;
            nmme_pkg::RegOwnInst:  own_inst_ff  <= csr_data;
            nmme_pkg::RegIgnProc:  ign_proc_ff  <= csr_data[0];
            nmme_pkg::RegIgnInst:  ign_inst_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // state
   nmme_pkg::state_type state_ff, state_in;
   logic [31:0] clk_s_ff;
   logic        self_m_ff, self_m_in, self_e_ff;
   logic [CW-1:0] pos_ff, pos_in;
   logic        found_ff, found_in, free_ok_ff, free_ok_in, was_m_ff, was_m_in;
   logic [SW-1:0] found_idx_ff, found_idx_in, free_ff, free_in;
   logic [8:0]  higher_ff, higher_in;
   logic        elig_hi_ff, elig_hi_in;
   logic [1:0]  emit_ff, emit_in;
   nmme_pkg::entry_type req_ff;
   logic        req_cm_ff;

   nmme_pkg::ctl_type   ctl;
   nmme_pkg::entry_type head, new_entry;

   nmme_ring u_ring (
      .clock(clock), .reset(reset), .ctl(ctl), .new_entry(new_entry), .head(head)
   );

   logic        scan_end, match, stale, hi;
   logic [31:0] age;
   logic [15:0] lim;
   logic        demote_c, promote_c;
   logic        strobe_in, last_in;
   logic [2:0]  ev_in;
   logic [SW-1:0] slot_in;
   logic [63:0] np_in, ni_in;
   logic        nm_in;

   assign scan_end = (pos_ff == CW'(nmme_pkg::TableDepth - 1));
   assign match = head.valid && head.process == req_ff.process
                  && head.instance_tag == req_ff.instance_tag;
   assign age   = clk_s_ff - head.seen;
   assign lim   = head.master ? master_to_ff : node_to_ff;
   assign stale = (clk_s_ff < head.seen) || (age > {16'd0, lim});
   assign hi    = $signed(weight_ff) < $signed(head.weight);
   assign demote_c  = self_m_ff && ({1'b0, mreq_ff} <= higher_ff);
   assign promote_c = !self_m_ff && self_e_ff && ({1'b0, mreq_ff} > higher_ff)
                      && !elig_hi_ff;
   assign busy = state_ff != nmme_pkg::ST_IDLE;

   always_comb begin
      new_entry          = req_ff;
      new_entry.valid    = 1'b1;
      if (found_ff) begin
         new_entry.process      = head.process;
         new_entry.instance_tag = head.instance_tag;
      end
   end

   always_comb begin
      state_in = state_ff; pos_in = pos_ff; found_in = found_ff;
      found_idx_in = found_idx_ff; free_ok_in = free_ok_ff; free_in = free_ff;
      was_m_in = was_m_ff; higher_in = higher_ff; elig_hi_in = elig_hi_ff;
      emit_in = emit_ff; self_m_in = self_m_ff;
      ctl = '0;
      strobe_in = 1'b0; last_in = 1'b0; ev_in = nmme_pkg::EvChecked;
      slot_in = '0; np_in = '0; ni_in = '0; nm_in = 1'b0;
      unique case (state_ff)
         nmme_pkg::ST_IDLE: begin
            pos_in = '0; found_in = 1'b0; free_ok_in = 1'b0; higher_in = '0;
            elig_hi_in = 1'b0; emit_in = '0;
            if (start) begin
               unique case (req_command)
                  nmme_pkg::CmdHello: begin
                     if (!((ign_proc_ff && req_process_tag == own_proc_ff) ||
                           (ign_inst_ff && req_instance_tag == own_inst_ff)))
                        state_in = nmme_pkg::ST_HSCAN;
                  end
                  nmme_pkg::CmdCheck: state_in = nmme_pkg::ST_CSCAN;
                  nmme_pkg::CmdPromote: self_m_in = 1'b1;
                  nmme_pkg::CmdDemote: self_m_in = 1'b0;
                  default: ;
               endcase
            end
         end
         nmme_pkg::ST_HSCAN: begin
            // first pass: look up; second pass: write into the chosen slot
            ctl.shift = 1'b1;
            if (!emit_ff[0]) begin
               if (match && !found_ff) begin
                  found_in = 1'b1; found_idx_in = pos_ff[SW-1:0];
                  was_m_in = head.master;
               end else if (!head.valid && !free_ok_ff) begin
                  free_ok_in = 1'b1; free_in = pos_ff[SW-1:0];
               end
               pos_in = pos_ff + 1'b1;
               if (scan_end) begin
                  pos_in = '0;
                  emit_in = 2'd1;
                  if (!found_in && !free_ok_in) begin
                     state_in = nmme_pkg::ST_HEMIT;
                     emit_in = 2'd3;
                  end
               end
            end else begin
               if (pos_ff[SW-1:0] == (found_ff ? found_idx_ff : free_ff))
                  ctl.load = 1'b1;
               pos_in = pos_ff + 1'b1;
               if (scan_end) begin
                  state_in = nmme_pkg::ST_HEMIT;
                  emit_in = found_ff ? 2'd2 : 2'd0;
               end
            end
         end
         nmme_pkg::ST_HEMIT: begin
            // emit_ff: 0 added, 1 master, 2 hello, 3 full
            strobe_in = 1'b1; np_in = req_ff.process; ni_in = req_ff.instance_tag;
            nm_in = req_cm_ff;
            slot_in = found_ff ? found_idx_ff : free_ff;
            unique case (emit_ff)
               2'd0: begin
                  ev_in = nmme_pkg::EvAdded;
                  emit_in = req_cm_ff ? 2'd1 : 2'd2;
               end
               2'd1: begin ev_in = nmme_pkg::EvMaster; emit_in = 2'd2; end
               2'd2: begin
                  ev_in = nmme_pkg::EvHello; last_in = 1'b1;
                  state_in = nmme_pkg::ST_IDLE;
               end
               default: begin
                  ev_in = nmme_pkg::EvFull; slot_in = '0; last_in = 1'b1;
                  state_in = nmme_pkg::ST_IDLE;
               end
            endcase
         end
         nmme_pkg::ST_CSCAN: begin
            ctl.shift = 1'b1;
            if (head.valid) begin
               if (stale) begin
                  ctl.clear = 1'b1; strobe_in = 1'b1; ev_in = nmme_pkg::EvRemoved;
                  slot_in = pos_ff[SW-1:0]; np_in = head.process;
                  ni_in = head.instance_tag; nm_in = head.master;
               end else if (head.master) begin
                  if (hi) higher_in = higher_ff + 1'b1;
               end else if (head.eligible && hi) begin
                  elig_hi_in = 1'b1;
               end
            end
            pos_in = pos_ff + 1'b1;
            if (scan_end) begin
               state_in = nmme_pkg::ST_CEMIT; emit_in = 2'd0;
            end
         end
         nmme_pkg::ST_CEMIT: begin
            strobe_in = 1'b1;
            if (emit_ff == 2'd0 && demote_c) begin
               ev_in = nmme_pkg::EvDemoted; self_m_in = 1'b0; emit_in = 2'd1;
            end else if (emit_ff == 2'd0 && promote_c) begin
               ev_in = nmme_pkg::EvPromoted; self_m_in = 1'b1; emit_in = 2'd1;
            end else begin
               ev_in = nmme_pkg::EvChecked; last_in = 1'b1;
               state_in = nmme_pkg::ST_IDLE;
            end
         end
         default: state_in = nmme_pkg::ST_IDLE;
      endcase
   end

   // became master decision for a known node: skip it when already master
   logic [1:0] emit_fix;
   always_comb begin
      emit_fix = emit_in;
      if (state_ff == nmme_pkg::ST_HSCAN && emit_ff[0] && scan_end && found_ff)
         emit_fix = (req_cm_ff && !was_m_ff) ? 2'd1 : 2'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nmme_pkg::ST_IDLE; clk_s_ff <= '0; self_m_ff <= 1'b0;
         self_e_ff <= 1'b1; pos_ff <= '0; found_ff <= 1'b0; free_ok_ff <= 1'b0;
         emit_ff <= '0; higher_ff <= '0; elig_hi_ff <= 1'b0; rsp_strobe <= 1'b0;
         was_m_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; found_ff <= found_in;
         free_ok_ff <= free_ok_in; emit_ff <= emit_fix; higher_ff <= higher_in;
         elig_hi_ff <= elig_hi_in; self_m_ff <= self_m_in; rsp_strobe <= strobe_in;
         was_m_ff <= was_m_in;
         if (state_ff == nmme_pkg::ST_IDLE && start) begin
            unique case (req_command)
               nmme_pkg::CmdTick: clk_s_ff <= clk_s_ff + 1'b1;
               nmme_pkg::CmdPromote: self_e_ff <= 1'b1;
               nmme_pkg::CmdDemote: self_e_ff <= !req_permanent;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff <= found_idx_in; free_ff <= free_in;
      rsp_event_res <= ev_in; rsp_slot <= 4'(slot_in);
      rsp_node_process <= np_in; rsp_node_instance <= ni_in;
      rsp_node_master <= nm_in; rsp_self_master <= self_m_in; rsp_last <= last_in;
      if (state_ff == nmme_pkg::ST_IDLE && start) begin
         req_ff.valid <= 1'b1; req_ff.process <= req_process_tag;
         req_ff.instance_tag <= req_instance_tag; req_ff.address <= req_sender_address;
         req_ff.port <= req_sender_port; req_ff.seen <= clk_s_ff;
         req_ff.master <= req_claims_master; req_ff.eligible <= req_claims_eligible;
         req_ff.weight <= req_sender_weight; req_cm_ff <= req_claims_master;
      end
   end
endmodule

FILE: rtl/nmme_checker.sv
// ----------------------------------------------------------------------------
// nmme_checker
// Port level checks on the command and result channels.
// ----------------------------------------------------------------------------
module nmme_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [2:0] rsp_event_res,
   input logic       rsp_last
);
   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe) else $error("last without strobe");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe) else $error("word after last");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_event_res == nmme_pkg::EvChecked ||
                     rsp_event_res == nmme_pkg::EvFull) |-> rsp_last)
      else $error("closing word not last");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy) else $error("idle mid item");
endmodule

bind node_membership_master_election nmme_checker u_nmme_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_event_res(rsp_event_res), .rsp_last(rsp_last)
);
